FILE: rtl/srat_pkg.sv
// shared widths, flag bytes and response kinds of the segment receive ack tracker
package srat_pkg;

    localparam int OFF_W  = 16;
    localparam int ID_W   = 32;
    localparam int FLAG_W = 8;
    localparam int LEN_W  = 9;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;

    // flag byte values
    localparam logic [FLAG_W-1:0] FLAG_SYN = 8'h04;
    localparam logic [FLAG_W-1:0] FLAG_FIN = 8'h02;
    localparam logic [FLAG_W-1:0] FLAG_RST = 8'h01;

    // lengths below this mark the last packet
    localparam logic [LEN_W-1:0] SHORT_LIMIT = 9'd255;
    localparam logic [OFF_W-1:0] OFFSET_MAX  = 16'hFFFF;

    // valid SYN command bytes
    localparam logic [BYTE_W-1:0] CMD_DOWNLOAD = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_UPLOAD   = 8'd2;

    // configuration register indexes
    localparam logic [0:0] REG_CONN_ID = 1'b0;
    localparam logic [0:0] REG_COMMAND = 1'b1;

    // response kinds
    localparam logic [KIND_W-1:0] KIND_ACK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FOREIGN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FINISHED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEER_RESET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ABORT      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLOSED     = 3'd5;

endpackage

FILE: rtl/srat_ram.sv
// generic simple dual port ram with registered read
module srat_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/srat_mod.sv
// reduction of a byte offset to a map index by reciprocal multiplication
module srat_mod #(
    parameter int MAP_DEPTH = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [srat_pkg::OFF_W-1:0]   i_value,
    output logic                         o_done,
    output logic [$clog2(MAP_DEPTH)-1:0] o_index
);
    import srat_pkg::*;

    localparam int IDX_W  = $clog2(MAP_DEPTH);
    localparam int SHIFT  = OFF_W + IDX_W;
    localparam int RCP_W  = OFF_W + 2;
    localparam int PROD_W = OFF_W + RCP_W;
    localparam int DEP_W  = OFF_W + 1;
    localparam int BACK_W = OFF_W + DEP_W;
    // floor(2^SHIFT / depth) + 1 gives the exact quotient for every 16-bit offset
    localparam logic [63:0]       RCP_WIDE = (64'd1 << SHIFT) / 64'(MAP_DEPTH) + 64'd1;
    localparam logic [RCP_W-1:0]  RCP      = RCP_WIDE[RCP_W-1:0];
    localparam logic [DEP_W-1:0]  DEPTH    = DEP_W'(MAP_DEPTH);

    logic [OFF_W-1:0]  r_val;
    logic [OFF_W-1:0]  r_quo, n_quo;
    logic [OFF_W-1:0]  r_rem, n_rem;
    logic              r_busy;
    logic              r_done;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quo_full;
    logic [BACK_W-1:0] back;

    // quotient from the reciprocal, then remainder from the quotient
    always_comb begin
        prod     = PROD_W'(i_value) * PROD_W'(RCP);
        quo_full = prod >> SHIFT;
        n_quo    = quo_full[OFF_W-1:0];
        back     = BACK_W'(r_quo) * BACK_W'(DEPTH);
        n_rem    = r_val - back[OFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_quo <= n_quo;
        end
        if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_done  = r_done;
    assign o_index = r_rem[IDX_W-1:0];

endmodule

FILE: rtl/segment_receive_ack_tracker_unit.sv
// top level of the segment receive ack tracker: sequencer around the received map ram
// a control beat goes from the idle state to the pending result, then to the output register,
// and input stall drops on the edge that loads it, so a new control beat is taken only once
// the last one has reached the output register; a data beat marks the map if it carries data,
// reads the map while the expected offset advances (at most MAP_DEPTH reads) and then clamps
// after reset a clearing pass writes MAP_DEPTH map entries, one per cycle, before the first beat

module segment_receive_ack_tracker_unit #(
    parameter int MAP_DEPTH   = 65536,
    parameter int CHUNK_BYTES = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [srat_pkg::ID_W-1:0]     i_cfg_data,
    // packet header channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [srat_pkg::ID_W-1:0]     i_pkt_id,
    input  logic [srat_pkg::OFF_W-1:0]    i_pkt_seq,
    input  logic [srat_pkg::OFF_W-1:0]    i_pkt_ack,
    input  logic [srat_pkg::FLAG_W-1:0]   i_pkt_flags,
    input  logic [srat_pkg::LEN_W-1:0]    i_pkt_len,
    input  logic [srat_pkg::BYTE_W-1:0]   i_first_byte,
    // response channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [srat_pkg::KIND_W-1:0]   o_response_kind,
    output logic [srat_pkg::ID_W-1:0]     o_reply_id,
    output logic [srat_pkg::OFF_W-1:0]    o_ack_value
);
    import srat_pkg::*;

    localparam int IDX_W  = $clog2(MAP_DEPTH);
    localparam int STEP_W = $clog2(MAP_DEPTH + 1);
    localparam logic [OFF_W-1:0]  CHUNK     = OFF_W'(CHUNK_BYTES);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(MAP_DEPTH);
    localparam logic [IDX_W-1:0]  CLR_LAST  = IDX_W'(MAP_DEPTH - 1);

    // sequencer states
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SMOD = 4'd2;
    localparam logic [3:0] ST_STEP = 4'd3;
    localparam logic [3:0] ST_EMOD = 4'd4;
    localparam logic [3:0] ST_RD   = 4'd5;
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [ID_W-1:0]   r_cid;
    logic [CMD_W-1:0]  r_cmd;
    logic [OFF_W-1:0]  r_exp, n_exp;
    logic [OFF_W-1:0]  r_end, n_end;
    logic              r_closed, n_closed;
    logic [OFF_W-1:0]  r_seq, n_seq;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_clr, n_clr;
    // pending result
    logic [KIND_W-1:0] r_pk, n_pk;
    logic [ID_W-1:0]   r_pid, n_pid;
    logic [OFF_W-1:0]  r_pack, n_pack;
    // output register
    logic              r_ov, n_ov;
    logic [KIND_W-1:0] r_ok, n_ok;
    logic [ID_W-1:0]   r_oid, n_oid;
    logic [OFF_W-1:0]  r_oack, n_oack;

    logic              in_take;
    logic              out_take;
    logic              mod_start;
    logic [OFF_W-1:0]  mod_value;
    logic              mod_done;
    logic [IDX_W-1:0]  mod_index;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_wdata;
    logic              ram_rdata;
    logic              is_fin0;
    logic              is_bad_syn;
    logic              is_valid_syn;
    logic              is_rst0;
    logic [OFF_W-1:0]  clamped;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_ov && !i_stall;

    // header classification
    assign is_fin0    = (i_pkt_len == '0) && (i_pkt_flags == FLAG_FIN);
    assign is_bad_syn = (i_pkt_flags == FLAG_SYN) &&
                        ((i_pkt_len == '0) ||
                         ((i_pkt_len != 9'd1) && (i_first_byte != CMD_DOWNLOAD) &&
                          (i_first_byte != CMD_UPLOAD)));
    assign is_valid_syn = (i_pkt_id != '0) && (i_pkt_seq == '0) && (i_pkt_ack == '0) &&
                          (i_pkt_flags == FLAG_SYN) && (i_pkt_len == 9'd1) &&
                          (i_first_byte == {6'd0, r_cmd});
    assign is_rst0    = (i_pkt_len == '0) && (i_pkt_flags == FLAG_RST);

    assign clamped = (r_exp > r_end) ? r_end : r_exp;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_exp     = r_exp;
        n_end     = r_end;
        n_closed  = r_closed;
        n_seq     = r_seq;
        n_steps   = r_steps;
        n_idx     = r_idx;
        n_clr     = r_clr;
        n_pk      = r_pk;
        n_pid     = r_pid;
        n_pack    = r_pack;
        n_ov      = r_ov && !out_take;
        n_ok      = r_ok;
        n_oid     = r_oid;
        n_oack    = r_oack;
        mod_start = 1'b0;
        mod_value = r_exp;
        ram_we    = 1'b0;
        ram_waddr = mod_index;
        ram_wdata = 1'b1;
        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 1'b0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_seq   = i_pkt_seq;
                    n_steps = '0;
                    n_pid   = r_cid;
                    n_pack  = '0;
                    n_state = ST_OUT;
                    priority if (r_closed) begin
                        n_pk = KIND_CLOSED;
                    end else if (is_fin0) begin
                        n_closed = 1'b1;
                        n_pk     = KIND_FINISHED;
                        n_pack   = r_exp;
                    end else if (is_bad_syn) begin
                        n_closed = 1'b1;
                        n_pk     = KIND_ABORT;
                    end else if (is_valid_syn || (i_pkt_id != r_cid)) begin
                        n_pk  = KIND_FOREIGN;
                        n_pid = i_pkt_id;
                    end else if (is_rst0) begin
                        n_closed = 1'b1;
                        n_pk     = KIND_PEER_RESET;
                    end else begin
                        // data packet
                        if ((i_pkt_len != '0) && (i_pkt_len < SHORT_LIMIT)) begin
                            n_end = i_pkt_seq + OFF_W'(i_pkt_len);
                        end
                        if (i_pkt_len != '0) begin
                            mod_start = 1'b1;
                            mod_value = i_pkt_seq;
                            n_state   = ST_SMOD;
                        end else if (r_exp == i_pkt_seq) begin
                            n_state = ST_STEP;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_SMOD: begin
                // mark the packet offset
                if (mod_done) begin
                    ram_we  = 1'b1;
                    n_state = (r_exp == r_seq) ? ST_STEP : ST_FIN;
                end
            end
            ST_STEP: begin
                if (r_steps == STEP_MAX) begin
                    n_state = ST_FIN;
                end else begin
                    mod_start = 1'b1;
                    n_state   = ST_EMOD;
                end
            end
            ST_EMOD: begin
                if (mod_done) begin
                    n_idx   = mod_index;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                // advance over a marked offset
                if (ram_rdata) begin
                    n_exp   = r_exp + CHUNK;
                    n_steps = r_steps + 1'b1;
                    n_state = ST_STEP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_exp   = clamped;
                n_pk    = KIND_ACK;
                n_pid   = r_cid;
                n_pack  = clamped;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ov || out_take) begin
                    n_ov    = 1'b1;
                    n_ok    = r_pk;
                    n_oid   = r_pid;
                    n_oack  = r_pack;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_exp    <= '0;
            r_end    <= OFFSET_MAX;
            r_closed <= 1'b0;
            r_ov     <= 1'b0;
            r_cid    <= '0;
            r_cmd    <= 2'd1;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_exp    <= n_exp;
            r_end    <= n_end;
            r_closed <= n_closed;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CONN_ID: r_cid <= i_cfg_data;
                    REG_COMMAND: r_cmd <= i_cfg_data[CMD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seq   <= n_seq;
        r_steps <= n_steps;
        r_idx   <= n_idx;
        r_pk    <= n_pk;
        r_pid   <= n_pid;
        r_pack  <= n_pack;
        r_ok    <= n_ok;
        r_oid   <= n_oid;
        r_oack  <= n_oack;
    end

    // offset to map index reduction
    srat_mod #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_index (mod_index)
    );

    // received map
    srat_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_valid         = r_ov;
    assign o_response_kind = r_ok;
    assign o_reply_id      = r_oid;
    assign o_ack_value     = r_oack;

endmodule
